// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for the RTL, included by ldu_face_sparse_matvec_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/ldu_pkg.sv =====
// ----------------------------------------------------------------------------
// ldu_pkg
// Types, codes and constants of the face-addressed sparse matvec block.
// ----------------------------------------------------------------------------
package ldu_pkg;

  localparam int MAX_CELLS_DEFAULT = 1024;
  localparam int CELL_CNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int DATA_W = 32;
  localparam int ACC_W = 40;
  localparam int Q_FRAC = 16;

  localparam logic [CELL_CNT_W-1:0] CELL_COUNT_RESET = 11'd1024;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FACE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  localparam logic [ACC_W-1:0] ACC_MAX = 40'h7F_FFFF_FFFF;
  localparam logic [ACC_W-1:0] ACC_MIN = 40'h80_0000_0000;

  typedef struct packed {
    logic [1:0] mode;
    logic [INDEX_W-1:0] cell_index;
    logic signed [DATA_W-1:0] diag_coef;
    logic signed [DATA_W-1:0] psi_value;
    logic [INDEX_W-1:0] lower_cell;
    logic [INDEX_W-1:0] upper_cell;
    logic signed [DATA_W-1:0] lower_coef;
    logic signed [DATA_W-1:0] upper_coef;
  } item_t;

  typedef struct packed {
    logic status;
    logic signed [ACC_W-1:0] result_value;
  } result_t;

endpackage

// ===== rtl/ldu_mac.sv =====
// ----------------------------------------------------------------------------
// ldu_mac
// Shared multiply-accumulate unit: registered product of Q16.16 operands,
// then rounding, accumulate and 40-bit saturation.
// ----------------------------------------------------------------------------
module ldu_mac
  import ldu_pkg::*;
(
  input  logic clk,
  input  logic mul_en,
  input  logic signed [DATA_W-1:0] mul_a,
  input  logic signed [DATA_W-1:0] mul_b,
  input  logic [ACC_W-1:0] acc,
  output logic [ACC_W-1:0] sum
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W = PROD_W - Q_FRAC + 1;

  logic signed [PROD_W-1:0] prod;
  logic [SUM_W-1:0] acc_ext;
  logic [SUM_W-1:0] rnd_ext;
  logic [SUM_W-1:0] total;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign acc_ext = {{(SUM_W-ACC_W){acc[ACC_W-1]}}, acc};
  assign rnd_ext = {prod[PROD_W-1], prod[PROD_W-1:Q_FRAC]};
  assign total = acc_ext + rnd_ext + SUM_W'(prod[Q_FRAC-1]);

  always_comb begin
    if (total[SUM_W-1:ACC_W-1] == {(SUM_W-ACC_W+1){total[SUM_W-1]}}) begin
      sum = total[ACC_W-1:0];
    end else if (total[SUM_W-1]) begin
      sum = ACC_MIN;
    end else begin
      sum = ACC_MAX;
    end
  end

endmodule

// ===== rtl/ldu_face_sparse_matvec_top.sv =====
// ----------------------------------------------------------------------------
// ldu_face_sparse_matvec_top
// Face-addressed sparse matrix-vector multiply y = A*x in LDU form.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive item and raise start; the transaction is taken at an edge
//   with start high and busy low. busy stays high while the item is worked.
//   Output: done strobes for one cycle with result; there is no back
//   pressure, so the receiver must take it in that cycle.
//   Config: cfg_data is written to cell_count on cfg_valid && cfg_ready;
//   cfg_ready is high while the block is idle.
// Sequence from accept to done (busy drops with done, so a next item can be
//   taken as done strobes): load LMUL, LWR; read RREQ, RDAT; unused mode or
//   out of range answers from IDLE. A face runs read, multiply, write-back
//   (FRD, FMUL, FWR) twice; one multiplier, two-port x and one-port y memory.
// Reset: cell_count returns to 1024, the sequencer idles and done drops.
//   x and y memories are not cleared; cells are loaded before use.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ldu_face_sparse_matvec_top
  import ldu_pkg::*;
#(
  parameter int MAX_CELLS = MAX_CELLS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  item_t item,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CELL_CNT_W-1:0] cfg_data,
  output logic done,
  output result_t result
);

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LMUL = 3'd1;
  localparam logic [2:0] ST_LWR = 3'd2;
  localparam logic [2:0] ST_RREQ = 3'd3;
  localparam logic [2:0] ST_RDAT = 3'd4;
  localparam logic [2:0] ST_FRD = 3'd5;
  localparam logic [2:0] ST_FMUL = 3'd6;
  localparam logic [2:0] ST_FWR = 3'd7;

  function automatic logic idx_ok(input logic [INDEX_W-1:0] idx,
                                  input logic [CELL_CNT_W-1:0] cnt);
    idx_ok = ({1'b0, idx} < cnt) && (32'(idx) < MAX_CELLS);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [INDEX_W-1:0] idx);
    logic [IW-1:0] ext;
    ext = IW'(idx);
    return ext[AW-1:0];
  endfunction

  logic [CELL_CNT_W-1:0] cell_count;
  logic [2:0] state;
  logic phase;
  item_t item_r;

  logic [DATA_W-1:0] x_mem [MAX_CELLS];
  logic [ACC_W-1:0] y_mem [MAX_CELLS];
  logic [DATA_W-1:0] x_rd;
  logic [ACC_W-1:0] y_rd;

  logic accept;
  logic x_we;
  logic y_we;
  logic [AW-1:0] ci_addr;
  logic [AW-1:0] lc_addr;
  logic [AW-1:0] uc_addr;
  logic [AW-1:0] x_raddr;
  logic [AW-1:0] y_addr;

  logic mul_en;
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic [ACC_W-1:0] mac_acc;
  logic [ACC_W-1:0] mac_sum;

  assign accept = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count <= CELL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cell_count <= cfg_data;
    end
  end

  assign ci_addr = to_addr(item_r.cell_index);
  assign lc_addr = to_addr(item_r.lower_cell);
  assign uc_addr = to_addr(item_r.upper_cell);

  assign x_we = (state == ST_LWR);
  assign y_we = (state == ST_LWR) || (state == ST_FWR);
  assign x_raddr = phase ? uc_addr : lc_addr;

  always_comb begin
    case (state)
      ST_LWR, ST_RREQ: y_addr = ci_addr;
      default: y_addr = phase ? lc_addr : uc_addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      x_mem[ci_addr] <= item_r.psi_value;
    end
    x_rd <= x_mem[x_raddr];
  end

  always_ff @(posedge clk) begin
    if (y_we) begin
      y_mem[y_addr] <= mac_sum;
    end
    y_rd <= y_mem[y_addr];
  end

  assign mul_en = (state == ST_LMUL) || (state == ST_FMUL);
  assign mul_a = (state == ST_LMUL) ? item_r.diag_coef
               : (phase ? item_r.upper_coef : item_r.lower_coef);
  assign mul_b = (state == ST_LMUL) ? item_r.psi_value : signed'(x_rd);
  assign mac_acc = (state == ST_LWR) ? '0 : y_rd;

  ldu_mac u_mac (
    .clk(clk),
    .mul_en(mul_en),
    .mul_a(mul_a),
    .mul_b(mul_b),
    .acc(mac_acc),
    .sum(mac_sum)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= 1'b0;
      phase <= 1'b0;
      done <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          phase <= 1'b0;
          if (accept) begin
            case (item.mode)
              MODE_LOAD: begin
                if (idx_ok(item.cell_index, cell_count)) begin
                  state <= ST_LMUL;
                  busy <= 1'b1;
                end else begin
                  done <= 1'b1;
                  result <= '{status: STATUS_RANGE, result_value: '0};
                end
              end
              MODE_READ: begin
                if (idx_ok(item.cell_index, cell_count)) begin
                  state <= ST_RREQ;
                  busy <= 1'b1;
                end else begin
                  done <= 1'b1;
                  result <= '{status: STATUS_RANGE, result_value: '0};
                end
              end
              MODE_FACE: begin
                if (idx_ok(item.lower_cell, cell_count) &&
                    idx_ok(item.upper_cell, cell_count)) begin
                  state <= ST_FRD;
                  busy <= 1'b1;
                end else begin
                  done <= 1'b1;
                  result <= '{status: STATUS_RANGE, result_value: '0};
                end
              end
              default: begin
                done <= 1'b1;
                result <= '{status: STATUS_OK, result_value: '0};
              end
            endcase
          end
        end
        ST_LMUL: begin
          state <= ST_LWR;
        end
        ST_LWR: begin
          state <= ST_IDLE;
          busy <= 1'b0;
          done <= 1'b1;
          result <= '{status: STATUS_OK, result_value: '0};
        end
        ST_RREQ: begin
          state <= ST_RDAT;
        end
        ST_RDAT: begin
          state <= ST_IDLE;
          busy <= 1'b0;
          done <= 1'b1;
          result <= '{status: STATUS_OK, result_value: y_rd};
        end
        ST_FRD: begin
          state <= ST_FMUL;
        end
        ST_FMUL: begin
          state <= ST_FWR;
        end
        ST_FWR: begin
          if (!phase) begin
            phase <= 1'b1;
            state <= ST_FRD;
          end else begin
            phase <= 1'b0;
            state <= ST_IDLE;
            busy <= 1'b0;
            done <= 1'b1;
            result <= '{status: STATUS_OK, result_value: '0};
          end
        end
        default: begin
          state <= ST_IDLE;
          busy <= 1'b0;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_busy_tracks_state, clk, rst, (state != ST_IDLE) == busy, "busy out of step with sequencer")
  `ASSERT_ALWAYS(a_done_not_busy, clk, rst, !(done && busy), "result strobed while busy")
  `ASSERT_NEXT(a_accept_progress, clk, rst, accept, done || busy, "accepted transaction dropped")
  `ASSERT_NEXT(a_face_second_half, clk, rst, (state == ST_FWR) && !phase, (state == ST_FRD) && phase, "face skipped second update")

endmodule
